// ===== hw/rtl/spq_pkg.sv =====
// Shared types, codes and defaults for the sorted priority queue.
package spq_pkg;

  // Default number of cells in the queue.
  localparam int unsigned DefaultDepth = 16;

  // Operation codes carried by the cmd field.
  localparam logic [1:0] CmdEnqueue = 2'd0;
  localparam logic [1:0] CmdDequeue = 2'd1;
  localparam logic [1:0] CmdFind    = 2'd2;

  // Status codes reported with every result.
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StEmpty    = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  // One queue entry.
  typedef struct packed {
    logic [7:0]  requested_id;
    logic [7:0]  requester_id;
    logic [15:0] popularity;
  } entry_t;

  // Operation broadcast to every cell in the same cycle.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_op_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    entry_t      head;
    logic [3:0]  found_index;
    logic [4:0]  entry_count;
  } result_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One cell of the queue: holds an entry and one stage of the search chain.
module spq_cell #(
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CellIdx = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::cell_op_t op_i,
  input  logic              cell_valid_i,
  input  spq_pkg::entry_t   left_entry_i,
  input  logic              left_ins_i,
  input  spq_pkg::entry_t   right_entry_i,
  output spq_pkg::entry_t   entry_o,
  output logic              ins_o,
  input  logic [7:0]        key_i,
  input  logic              found_i,
  input  logic [IdxW-1:0]   idx_i,
  output logic              found_o,
  output logic [IdxW-1:0]   idx_o
);
  import spq_pkg::*;

  entry_t          entry_q, entry_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            match;

  // The new entry belongs at or before this cell when the cell is empty or
  // holds a strictly smaller popularity.
  assign ins_o = !cell_valid_i || (op_i.new_entry.popularity > entry_q.popularity);

  // Entry update: insert, shift towards the tail, or shift towards the head.
  always_comb begin
    entry_d = entry_q;
    if (op_i.enq && ins_o) begin
      entry_d = left_ins_i ? left_entry_i : op_i.new_entry;
    end else if (op_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Search stage: the first match seen along the chain is kept.
  assign match = cell_valid_i && (entry_q.requester_id == key_i);

  always_comb begin
    found_d = found_i;
    idx_d   = idx_i;
    if (!found_i) begin
      found_d = match;
      idx_d   = match ? IdxW'(CellIdx) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  assign entry_o = entry_q;
  assign found_o = found_q;
  assign idx_o   = idx_q;

endmodule

// ===== hw/rtl/spq_out_buf.sv =====
// Two-slot result buffer between the queue core and the output channel.
module spq_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  spq_pkg::result_t res_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output spq_pkg::result_t res_o
);
  import spq_pkg::*;

  result_t    slot0_q, slot0_d, slot1_q, slot1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign space_o     = (cnt_q != 2'd2);

  // Slot zero is the beat on offer; a push lands behind what remains.
  always_comb begin
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (pop) begin
      slot0_d = slot1_q;
    end
    if (push_i) begin
      if ((cnt_q - {1'b0, pop}) == 2'd0) begin
        slot0_d = res_i;
      end else begin
        slot1_d = res_i;
      end
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign res_o = slot0_q;

endmodule

// ===== hw/rtl/sorted_priority_queue_with_search.sv =====
// Top level of the sorted priority queue with search by requester id.
//
// The queue is a row of QUEUE_DEPTH cells kept sorted by descending
// popularity, with equal popularity in arrival order. An enqueue or a dequeue
// is applied to every cell in the cycle its beat is accepted, and its result
// is pushed into the result buffer in that same cycle. A find sends a token
// down the row of cells, one cell per cycle; its result is pushed when the
// token has passed the last cell, and no new beat is taken while the search
// runs. Results pass through a two-beat buffer, so input beats are accepted
// while no search runs and fewer than two results wait on the output side.
module sorted_priority_queue_with_search #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  in_requested_id_i,
  input  logic [7:0]  in_requester_id_i,
  input  logic [15:0] in_popularity_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_requested_id_o,
  output logic [7:0]  out_requester_id_o,
  output logic [15:0] out_popularity_o,
  output logic [3:0]  found_index_o,
  output logic [4:0]  entry_count_o
);
  import spq_pkg::*;

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  entry_t          ent   [QUEUE_DEPTH];
  logic            ins   [QUEUE_DEPTH];
  logic            fnd   [QUEUE_DEPTH];
  logic [IdxW-1:0] idxs  [QUEUE_DEPTH];

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] timer_q, timer_d;
  logic            busy_q, busy_d;
  logic [7:0]      key_q;
  logic            accept, full, empty, space, push, search_done;
  cell_op_t        op;
  result_t         res, res_out;
  logic [CntW+4:0] count_ext;
  logic [IdxW+3:0] idx_ext;

  assign accept = in_valid_i && in_ready_o;
  assign full   = (count_q == CntW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  assign in_ready_o = !busy_q && space;

  // Operation broadcast to the cell row.
  assign op.enq                    = accept && (cmd_i == CmdEnqueue) && !full;
  assign op.deq                    = accept && (cmd_i == CmdDequeue) && !empty;
  assign op.new_entry.requested_id = in_requested_id_i;
  assign op.new_entry.requester_id = in_requester_id_i;
  assign op.new_entry.popularity   = in_popularity_i;

  // Row of cells, each wired to its neighbours.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t          left_entry, right_entry;
    logic            left_ins, left_found;
    logic [IdxW-1:0] left_idx;

    if (i == 0) begin : g_head
      assign left_entry = op.new_entry;
      assign left_ins   = 1'b0;
      assign left_found = 1'b0;
      assign left_idx   = '0;
    end else begin : g_body
      assign left_entry = ent[i-1];
      assign left_ins   = ins[i-1];
      assign left_found = fnd[i-1];
      assign left_idx   = idxs[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = ent[i];
    end else begin : g_inner
      assign right_entry = ent[i+1];
    end

    spq_cell #(
      .IdxW    (IdxW),
      .CellIdx (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .op_i          (op),
      .cell_valid_i  (count_q > CntW'(i)),
      .left_entry_i  (left_entry),
      .left_ins_i    (left_ins),
      .right_entry_i (right_entry),
      .entry_o       (ent[i]),
      .ins_o         (ins[i]),
      .key_i         (key_q),
      .found_i       (left_found),
      .idx_i         (left_idx),
      .found_o       (fnd[i]),
      .idx_o         (idxs[i])
    );
  end

  // Occupancy and search sequencing.
  assign search_done = busy_q && (timer_q == CntW'(QUEUE_DEPTH));

  always_comb begin
    count_d = count_q;
    if (op.enq) begin
      count_d = count_q + CntW'(1);
    end else if (op.deq) begin
      count_d = count_q - CntW'(1);
    end
    busy_d  = busy_q;
    timer_d = timer_q;
    if (accept && (cmd_i == CmdFind)) begin
      busy_d  = 1'b1;
      timer_d = '0;
    end else if (search_done) begin
      busy_d  = 1'b0;
    end else if (busy_q) begin
      timer_d = timer_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      timer_q <= '0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
      timer_q <= timer_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= in_requester_id_i;
    end
  end

  // Result of the beat: immediate for enqueue and dequeue, delayed for find.
  assign count_ext = {5'b0, count_d};
  assign idx_ext   = {4'b0, idxs[QUEUE_DEPTH-1]};

  always_comb begin
    res             = '0;
    res.entry_count = count_ext[4:0];
    if (search_done) begin
      if (fnd[QUEUE_DEPTH-1]) begin
        res.status      = StOk;
        res.found_index = idx_ext[3:0];
      end else begin
        res.status      = StNotFound;
      end
    end else begin
      case (cmd_i)
        CmdEnqueue: res.status = full ? StFull : StOk;
        CmdDequeue: begin
          if (empty) begin
            res.status = StEmpty;
          end else begin
            res.status = StOk;
            res.head   = ent[0];
          end
        end
        default:    res.status = StOk;
      endcase
    end
  end

  assign push = search_done || (accept && (cmd_i != CmdFind));

  spq_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .res_i       (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign status_o           = res_out.status;
  assign out_requested_id_o = res_out.head.requested_id;
  assign out_requester_id_o = res_out.head.requester_id;
  assign out_popularity_o   = res_out.head.popularity;
  assign found_index_o      = res_out.found_index;
  assign entry_count_o      = res_out.entry_count;

endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::DefaultDepth
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  cmd_i,
  input logic [7:0]  in_requested_id_i,
  input logic [7:0]  in_requester_id_i,
  input logic [15:0] in_popularity_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  status_o,
  input logic [7:0]  out_requested_id_o,
  input logic [7:0]  out_requester_id_o,
  input logic [15:0] out_popularity_o,
  input logic [3:0]  found_index_o,
  input logic [4:0]  entry_count_o
);
  import spq_pkg::*;

  localparam logic [36:0] DepthExt = 37'(QUEUE_DEPTH);

  // A waiting input beat stays on offer with its payload unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(cmd_i) &&
      $stable(in_requested_id_i) && $stable(in_requester_id_i) &&
      $stable(in_popularity_i))
    else $error("input beat changed before it was taken");

  // A stalled result beat stays on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat withdrawn before it was taken");

  // A dequeue on an empty queue reports zero data and zero entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StEmpty) |->
      (out_requested_id_o == 8'd0) && (out_requester_id_o == 8'd0) &&
      (out_popularity_o == 16'd0) && (found_index_o == 4'd0) &&
      (entry_count_o == 5'd0))
    else $error("empty dequeue carries data or a non-zero count");

  // A full status reports the queue depth as its entry count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StFull) |-> (entry_count_o == DepthExt[4:0]))
    else $error("full status with a count other than the depth");

  // The reported count never exceeds the depth; not checked for depths above 31.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (QUEUE_DEPTH > 31) || (37'(entry_count_o) <= DepthExt))
    else $error("entry count beyond the queue depth");

endmodule

bind sorted_priority_queue_with_search spq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_spq_checker (.*);
